// ----- hdl/pip_pkg.sv -----
// ----------------------------------------------------------------------------
// pip_pkg
// Shared types and constants of the point-in-polygon crossing-number core.
// ----------------------------------------------------------------------------
package pip_pkg;

   localparam int unsigned COORD_W          = 32;
   localparam int unsigned IDX_W            = 6;
   localparam int unsigned CNT_OUT_W        = 7;
   localparam int unsigned DEF_MAX_VERTICES = 64;
   localparam int unsigned QUEUE_DEPTH      = 2;

   localparam logic                 REQ_WRITE = 1'b0;
   localparam logic                 REQ_QUERY = 1'b1;
   localparam logic [CNT_OUT_W-1:0] CROSS_SAT = 7'd127;

   typedef enum logic [1:0] {
      OP_WRITE = 2'd0,
      OP_DROP  = 2'd1,
      OP_QUERY = 2'd2
   } pip_op_type;

   typedef struct packed {
      logic                      req_type;
      logic [IDX_W-1:0]          vertex_index;
      logic signed [COORD_W-1:0] coord_x;
      logic signed [COORD_W-1:0] coord_y;
   } pip_req_type;

   typedef struct packed {
      logic                 inside_res;
      logic [CNT_OUT_W-1:0] crossings;
   } pip_rsp_type;

   typedef struct packed {
      pip_op_type                op;
      logic [IDX_W-1:0]          vertex_index;
      logic signed [COORD_W-1:0] coord_x;
      logic signed [COORD_W-1:0] coord_y;
   } pip_cmd_type;

endpackage

// ----- hdl/pip_front.sv -----
// ----------------------------------------------------------------------------
// pip_front
// Request intake: classifies each request and holds it in a short queue
// until the edge walker takes it.
// ----------------------------------------------------------------------------
module pip_front #(
   parameter int unsigned MAX_VERTICES = pip_pkg::DEF_MAX_VERTICES
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   output logic                  req_full,
   input  pip_pkg::pip_req_type  req_payload,
   output logic                  cmd_valid,
   input  logic                  cmd_pop,
   output pip_pkg::pip_cmd_type  cmd_data
);
   import pip_pkg::*;

   localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam int unsigned CW    = $clog2(MAX_VERTICES + 1);
   localparam int unsigned SW    = (CW > IDX_W) ? CW : IDX_W;

   pip_cmd_type      queue_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push_ok;
   logic             pop_ok;
   logic [SW-1:0]    slot_ext;
   pip_cmd_type      cmd_new;

   assign req_full  = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign cmd_valid = (count_ff != '0);
   assign cmd_data  = queue_ff[rd_ptr_ff];
   assign push_ok   = req_push && !req_full;
   assign pop_ok    = cmd_pop && cmd_valid;
   assign slot_ext  = SW'(req_payload.vertex_index);

   // classify: query, in-range write, or write beyond the store
   always_comb begin
      cmd_new.vertex_index = req_payload.vertex_index;
      cmd_new.coord_x      = req_payload.coord_x;
      cmd_new.coord_y      = req_payload.coord_y;
      if (req_payload.req_type == REQ_QUERY) begin
         cmd_new.op = OP_QUERY;
      end else if (slot_ext < SW'(MAX_VERTICES)) begin
         cmd_new.op = OP_WRITE;
      end else begin
         cmd_new.op = OP_DROP;
      end
   end

   always_comb begin
      wr_ptr_in = push_ok ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop_ok ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push_ok && !pop_ok) begin
         count_in = count_ff + 1'b1;
      end else if (pop_ok && !push_ok) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         queue_ff[wr_ptr_ff] <= cmd_new;
      end
   end

endmodule

// ----- hdl/pip_back.sv -----
// ----------------------------------------------------------------------------
// pip_back
// Vertex store and edge walker: applies vertex writes and runs each query
// over all edges through a five-stage compare pipeline.
// ----------------------------------------------------------------------------
module pip_back #(
   parameter int unsigned MAX_VERTICES = pip_pkg::DEF_MAX_VERTICES
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            cmd_valid,
   output logic                            cmd_pop,
   input  pip_pkg::pip_cmd_type            cmd_data,
   input  logic [pip_pkg::CNT_OUT_W-1:0]   vertex_count,
   output logic                            rsp_valid,
   input  logic                            rsp_take,
   output pip_pkg::pip_rsp_type            rsp_data
);
   import pip_pkg::*;

   localparam int unsigned AW = $clog2(MAX_VERTICES);
   localparam int unsigned CW = $clog2(MAX_VERTICES + 1);
   localparam int unsigned NW = (CW > CNT_OUT_W) ? CW : CNT_OUT_W;
   localparam int unsigned SW = (AW > IDX_W) ? AW : IDX_W;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_WALK  = 3'b010,
      ST_DRAIN = 3'b100
   } back_state_type;

   function automatic logic [COORD_W-1:0] mag33(input logic signed [COORD_W:0] v);
      logic [COORD_W:0] t;
      t = v[COORD_W] ? -v : v;
      return t[COORD_W-1:0];
   endfunction

   logic [COORD_W-1:0] vert_x_store [MAX_VERTICES];
   logic [COORD_W-1:0] vert_y_store [MAX_VERTICES];

   back_state_type state_ff, state_in;
   logic [CW-1:0]  k_ff, k_in;
   logic [CW-1:0]  n_ff, n_in;
   logic signed [COORD_W-1:0] qx_ff, qx_in;
   logic signed [COORD_W-1:0] qy_ff, qy_in;

   logic [NW-1:0]  cnt_ext;
   logic [CW-1:0]  n_sel;
   logic [SW-1:0]  slot_ext;
   logic           mem_we;
   logic           rd_en, rd_prime, rd_last;
   logic [AW-1:0]  rd_addr;
   logic           start, zero_result;

   // stage 1: read data
   logic                      s1_vld_ff, s1_prime_ff, s1_last_ff;
   logic signed [COORD_W-1:0] rd_x_ff, rd_y_ff;
   logic signed [COORD_W-1:0] prev_x_ff, prev_y_ff;
   logic                      edge_vld;

   // stage 2: differences
   logic                      s2_vld_ff, s2_last_ff, s2_str_ff;
   logic signed [COORD_W:0]   d_px_ff, d_dy_ff, d_ex_ff, d_py_ff;

   // stage 3: sign and magnitude
   logic                      s3_vld_ff, s3_last_ff, s3_str_ff;
   logic                      s3_lsg_ff, s3_rsg_ff, s3_dypos_ff;
   logic [COORD_W-1:0]        m_px_ff, m_dy_ff, m_ex_ff, m_py_ff;

   // stage 4: products
   logic                      s4_vld_ff, s4_last_ff, s4_str_ff;
   logic                      s4_lsg_ff, s4_rsg_ff, s4_dypos_ff;
   logic [2*COORD_W-1:0]      p_l_ff, p_r_ff;

   // stage 5: compare and count
   logic                      l_neg, r_neg, mag_lt, mag_gt, l_lt_r, r_lt_l, hit;
   logic [CNT_OUT_W-1:0]      cnt_ff, cnt_in;
   logic                      par_ff, par_in;
   logic                      rsp_valid_ff;
   pip_rsp_type               rsp_data_ff;

   assign cnt_ext  = NW'(vertex_count);
   assign n_sel    = (cnt_ext > NW'(MAX_VERTICES)) ? CW'(MAX_VERTICES) : cnt_ext[CW-1:0];
   assign slot_ext = SW'(cmd_data.vertex_index);

   always_comb begin
      state_in    = state_ff;
      k_in        = k_ff;
      n_in        = n_ff;
      qx_in       = qx_ff;
      qy_in       = qy_ff;
      cmd_pop     = 1'b0;
      mem_we      = 1'b0;
      rd_en       = 1'b0;
      rd_prime    = 1'b0;
      rd_last     = 1'b0;
      rd_addr     = '0;
      start       = 1'b0;
      zero_result = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               unique case (cmd_data.op)
                  OP_WRITE: begin
                     cmd_pop = 1'b1;
                     mem_we  = 1'b1;
                  end
                  OP_QUERY: begin
                     if (!rsp_valid_ff) begin
                        cmd_pop = 1'b1;
                        start   = 1'b1;
                        qx_in   = cmd_data.coord_x;
                        qy_in   = cmd_data.coord_y;
                        n_in    = n_sel;
                        k_in    = '0;
                        if (n_sel == '0) begin
                           zero_result = 1'b1;
                        end else begin
                           state_in = ST_WALK;
                        end
                     end
                  end
                  default: begin
                     cmd_pop = 1'b1;
                  end
               endcase
            end
         end
         ST_WALK: begin
            // prime with the last vertex, then stream vertices 0 .. n-1
            rd_en    = 1'b1;
            rd_prime = (k_ff == '0);
            rd_last  = (k_ff == n_ff);
            rd_addr  = rd_prime ? AW'(n_ff - 1'b1) : AW'(k_ff - 1'b1);
            k_in     = k_ff + 1'b1;
            if (rd_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (s4_vld_ff && s4_last_ff) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         k_ff     <= '0;
         n_ff     <= '0;
      end else begin
         state_ff <= state_in;
         k_ff     <= k_in;
         n_ff     <= n_in;
      end
   end

   always_ff @(posedge clock) begin
      qx_ff <= qx_in;
      qy_ff <= qy_in;
   end

   // vertex store
   always_ff @(posedge clock) begin
      if (mem_we) begin
         vert_x_store[slot_ext[AW-1:0]] <= cmd_data.coord_x;
         vert_y_store[slot_ext[AW-1:0]] <= cmd_data.coord_y;
      end
      if (rd_en) begin
         rd_x_ff <= vert_x_store[rd_addr];
         rd_y_ff <= vert_y_store[rd_addr];
      end
   end

   assign edge_vld = s1_vld_ff && !s1_prime_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
         s4_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= rd_en;
         s2_vld_ff <= edge_vld;
         s3_vld_ff <= s2_vld_ff;
         s4_vld_ff <= s3_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_prime_ff <= rd_prime;
      s1_last_ff  <= rd_last;
      if (s1_vld_ff) begin
         prev_x_ff <= rd_x_ff;
         prev_y_ff <= rd_y_ff;
      end

      // edge (i, j): i is the vertex just read, j the one before it
      s2_last_ff <= s1_last_ff;
      s2_str_ff  <= (rd_y_ff > qy_ff) != (prev_y_ff > qy_ff);
      d_px_ff    <= {qx_ff[COORD_W-1], qx_ff} - {rd_x_ff[COORD_W-1], rd_x_ff};
      d_dy_ff    <= {prev_y_ff[COORD_W-1], prev_y_ff} - {rd_y_ff[COORD_W-1], rd_y_ff};
      d_ex_ff    <= {prev_x_ff[COORD_W-1], prev_x_ff} - {rd_x_ff[COORD_W-1], rd_x_ff};
      d_py_ff    <= {qy_ff[COORD_W-1], qy_ff} - {rd_y_ff[COORD_W-1], rd_y_ff};

      s3_last_ff  <= s2_last_ff;
      s3_str_ff   <= s2_str_ff;
      s3_lsg_ff   <= d_px_ff[COORD_W] ^ d_dy_ff[COORD_W];
      s3_rsg_ff   <= d_ex_ff[COORD_W] ^ d_py_ff[COORD_W];
      s3_dypos_ff <= !d_dy_ff[COORD_W];
      m_px_ff     <= mag33(d_px_ff);
      m_dy_ff     <= mag33(d_dy_ff);
      m_ex_ff     <= mag33(d_ex_ff);
      m_py_ff     <= mag33(d_py_ff);

      s4_last_ff  <= s3_last_ff;
      s4_str_ff   <= s3_str_ff;
      s4_lsg_ff   <= s3_lsg_ff;
      s4_rsg_ff   <= s3_rsg_ff;
      s4_dypos_ff <= s3_dypos_ff;
      p_l_ff      <= m_px_ff * m_dy_ff;
      p_r_ff      <= m_ex_ff * m_py_ff;
   end

   always_comb begin
      l_neg  = s4_lsg_ff && (p_l_ff != '0);
      r_neg  = s4_rsg_ff && (p_r_ff != '0);
      mag_lt = p_l_ff < p_r_ff;
      mag_gt = p_l_ff > p_r_ff;
      l_lt_r = (l_neg != r_neg) ? l_neg : (l_neg ? mag_gt : mag_lt);
      r_lt_l = (l_neg != r_neg) ? r_neg : (r_neg ? mag_lt : mag_gt);
      hit    = s4_vld_ff && s4_str_ff && (s4_dypos_ff ? l_lt_r : r_lt_l);
      cnt_in = cnt_ff;
      par_in = par_ff;
      if (hit) begin
         par_in = !par_ff;
         if (cnt_ff != CROSS_SAT) begin
            cnt_in = cnt_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         par_ff <= 1'b0;
      end else if (start) begin
         cnt_ff <= '0;
         par_ff <= 1'b0;
      end else if (s4_vld_ff) begin
         cnt_ff <= cnt_in;
         par_ff <= par_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         priority if (zero_result) begin
            rsp_valid_ff <= 1'b1;
         end else if (s4_vld_ff && s4_last_ff) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_take) begin
            rsp_valid_ff <= 1'b0;
         end else begin
            rsp_valid_ff <= rsp_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (zero_result) begin
         rsp_data_ff.inside_res <= 1'b0;
         rsp_data_ff.crossings  <= '0;
      end else if (s4_vld_ff && s4_last_ff) begin
         rsp_data_ff.inside_res <= par_in;
         rsp_data_ff.crossings  <= cnt_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ----- hdl/point_in_polygon_test_core.sv -----
// ----------------------------------------------------------------------------
// point_in_polygon_test_core
// Even-odd crossing-number test of a point against a stored polygon.
// ----------------------------------------------------------------------------
// A query uses n vertices (n = min(vertex_count, MAX_VERTICES)). The walker
// reads one vertex per cycle from the single read port of the vertex store,
// one extra read primes the wrap-around edge, and the compare pipeline is
// five stages deep. A query with zero vertices answers in the next cycle
// without a walk. A query leaves the queue only once the previous response
// has been popped. Write vertex_count through csr_ only while the core is
// idle; counts above MAX_VERTICES are clamped. No clearing pass is needed
// after reset.
module point_in_polygon_test_core #(
   parameter int unsigned MAX_VERTICES = pip_pkg::DEF_MAX_VERTICES
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_push,
   output logic                           req_full,
   input  pip_pkg::pip_req_type           req_payload,
   output logic                           rsp_empty,
   input  logic                           rsp_pop,
   output pip_pkg::pip_rsp_type           rsp_payload,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [pip_pkg::CNT_OUT_W-1:0]  csr_data
);
   import pip_pkg::*;

   logic [CNT_OUT_W-1:0] vertex_count_ff;
   logic                 cmd_valid;
   logic                 cmd_pop;
   pip_cmd_type          cmd_data;
   logic                 rsp_valid;

   assign csr_ready = 1'b1;
   assign rsp_empty = !rsp_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         vertex_count_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         vertex_count_ff <= csr_data;
      end
   end

   pip_front #(
      .MAX_VERTICES (MAX_VERTICES)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_full    (req_full),
      .req_payload (req_payload),
      .cmd_valid   (cmd_valid),
      .cmd_pop     (cmd_pop),
      .cmd_data    (cmd_data)
   );

   pip_back #(
      .MAX_VERTICES (MAX_VERTICES)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .cmd_valid    (cmd_valid),
      .cmd_pop      (cmd_pop),
      .cmd_data     (cmd_data),
      .vertex_count (vertex_count_ff),
      .rsp_valid    (rsp_valid),
      .rsp_take     (rsp_pop),
      .rsp_data     (rsp_payload)
   );

endmodule

// ----- hdl/pip_checker.sv -----
// ----------------------------------------------------------------------------
// pip_checker
// Port-level checks of the point-in-polygon core, bound to the top level.
// ----------------------------------------------------------------------------
module pip_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_empty,
   input logic                  rsp_pop,
   input pip_pkg::pip_rsp_type  rsp_payload
);
   import pip_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> $stable(rsp_payload))
      else $error("response changed while waiting");

   a_parity: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && (rsp_payload.crossings != CROSS_SAT))
         |-> (rsp_payload.inside_res == rsp_payload.crossings[0]))
      else $error("inside flag disagrees with crossing parity");

   a_reset_empty: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> rsp_empty)
      else $error("response present right after reset");

   a_drain_on_pop: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_empty) |-> $past(rsp_pop))
      else $error("response dropped without a pop");

endmodule

bind point_in_polygon_test_core pip_checker u_pip_checker (.*);

// ----- verif/point_in_polygon_test_core_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// point_in_polygon_test_core_tb
// Self-checking bench for the even-odd crossing-number core. A directed run
// covers an empty polygon, a single vertex, a small square and a square on
// the coordinate extremes. It then sweeps many vertex counts, including
// clamped counts, with random polygons and query points placed near the
// vertices. Each query response is checked against an exact in-bench
// crossing count. Both sides of the queue interface idle at random, and one
// long response stall backs the core up until its request side is full.
// ----------------------------------------------------------------------------
module point_in_polygon_test_core_tb;
   import pip_pkg::*;

   localparam int unsigned MAX_VERTS    = DEF_MAX_VERTICES;
   localparam int unsigned ITEM_TARGET  = 1950;
   localparam int unsigned DRAIN_CYCLES = MAX_VERTS + 60;
   localparam int unsigned HOLD_CYCLES  = 600;

   localparam int unsigned SCALE_UNIT = 0;
   localparam int unsigned SCALE_MID  = 1;
   localparam int unsigned SCALE_FULL = 2;
   localparam int unsigned SCALE_EDGE = 3;

   localparam logic signed [COORD_W-1:0] C_MIN = 32'sh8000_0000;
   localparam logic signed [COORD_W-1:0] C_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [COORD_W-1:0] SQ    = 32'sd6553600;

   logic                 clock       = 1'b0;
   logic                 reset       = 1'b1;
   logic                 req_push    = 1'b0;
   logic                 req_full;
   pip_req_type          req_payload = '0;
   logic                 rsp_empty;
   logic                 rsp_pop     = 1'b0;
   pip_rsp_type          rsp_payload;
   logic                 csr_valid   = 1'b0;
   logic                 csr_ready;
   logic [CNT_OUT_W-1:0] csr_data    = '0;
   logic                 rx_hold     = 1'b0;

   pip_req_type request_queue[$];
   pip_rsp_type pending_verdicts[$];

   logic signed [COORD_W-1:0] poly_x [MAX_VERTS];
   logic signed [COORD_W-1:0] poly_y [MAX_VERTS];
   logic signed [COORD_W-1:0] gen_x  [MAX_VERTS];
   logic signed [COORD_W-1:0] gen_y  [MAX_VERTS];
   logic                      gen_written [MAX_VERTS];
   int unsigned               poly_count = 0;

   int unsigned tx_idle_pct    = 25;
   int unsigned rx_idle_pct    = 25;
   int unsigned tx_gap         = 0;
   int unsigned rx_gap         = 0;
   int unsigned issued_count   = 0;
   int unsigned accepted_count = 0;
   int unsigned write_count    = 0;
   int unsigned query_count    = 0;
   int unsigned inside_hits    = 0;
   int unsigned full_stalls    = 0;
   int unsigned settings_count = 0;
   int unsigned mismatch_count = 0;

   point_in_polygon_test_core #(
      .MAX_VERTICES (MAX_VERTS)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_full    (req_full),
      .req_payload (req_payload),
      .rsp_empty   (rsp_empty),
      .rsp_pop     (rsp_pop),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_data    (csr_data)
   );

   always #2 clock = ~clock;

   function automatic int unsigned pick_gap(input int unsigned pct);
      if ($urandom_range(0, 99) >= pct) begin
         return 0;
      end
      if ($urandom_range(0, 19) < 17) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 40);
   endfunction

   function automatic int unsigned idle_choice();
      case ($urandom_range(0, 2))
         0: return 0;
         1: return 25;
         default: return 60;
      endcase
   endfunction

   function automatic logic signed [COORD_W-1:0] rand_coord(input int unsigned scale);
      logic signed [COORD_W-1:0] c;
      case (scale)
         SCALE_UNIT: c = (int'($urandom_range(0, 128)) - 64) * 65536;
         SCALE_MID:  c = int'($urandom()) >>> 10;
         SCALE_EDGE: begin
            case ($urandom_range(0, 4))
               0: c = C_MIN;
               1: c = C_MAX;
               2: c = '0;
               3: c = -1;
               default: c = 1;
            endcase
         end
         default: c = $urandom();
      endcase
      return c;
   endfunction

   // exact crossing count: compare cross products instead of dividing
   function automatic int unsigned count_crossings(input logic signed [COORD_W-1:0] px,
                                                   input logic signed [COORD_W-1:0] py);
      int unsigned              n, i, j, c;
      logic                     above_i, above_j;
      logic signed [COORD_W+1:0]   dy, dx_p, dx_e, dy_p;
      logic signed [2*COORD_W+3:0] lhs, rhs;
      n = (poly_count > MAX_VERTS) ? MAX_VERTS : poly_count;
      c = 0;
      for (i = 0; i < n; i++) begin
         j = (i == 0) ? n - 1 : i - 1;
         above_i = poly_y[i] > py;
         above_j = poly_y[j] > py;
         if (above_i != above_j) begin
            dy   = poly_y[j] - poly_y[i];
            dx_p = px - poly_x[i];
            dx_e = poly_x[j] - poly_x[i];
            dy_p = py - poly_y[i];
            lhs  = dx_p * dy;
            rhs  = dx_e * dy_p;
            if ((dy > 0) ? (lhs < rhs) : (rhs < lhs)) begin
               c++;
            end
         end
      end
      return c;
   endfunction

   task automatic apply_request(input pip_req_type r);
      pip_rsp_type verdict;
      int unsigned c;
      accepted_count++;
      if (r.req_type == REQ_WRITE) begin
         if (r.vertex_index < MAX_VERTS) begin
            poly_x[r.vertex_index] = r.coord_x;
            poly_y[r.vertex_index] = r.coord_y;
         end
         write_count++;
      end else begin
         c = count_crossings(r.coord_x, r.coord_y);
         verdict.inside_res = c[0];
         verdict.crossings  = (c > 127) ? CROSS_SAT : CNT_OUT_W'(c);
         pending_verdicts = {pending_verdicts, verdict};
         query_count++;
         if (c[0]) begin
            inside_hits++;
         end
      end
   endtask

   always @(posedge clock) begin
      pip_req_type item;
      if (reset) begin
         req_push <= 1'b0;
         tx_gap   <= 0;
      end else begin
         if (req_push && !req_full) begin
            apply_request(req_payload);
         end
         if (req_push && req_full) begin
            full_stalls++;
         end else if (tx_gap != 0) begin
            tx_gap   <= tx_gap - 1;
            req_push <= 1'b0;
         end else if (request_queue.size() != 0) begin
            item = request_queue.pop_front();
            req_payload <= item;
            req_push    <= 1'b1;
            tx_gap      <= pick_gap(tx_idle_pct);
         end else begin
            req_push <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      pip_rsp_type want;
      if (reset) begin
         rsp_pop <= 1'b0;
         rx_gap  <= 0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (pending_verdicts.size() == 0) begin
               $display("%0t: response with no query pending, got inside_res %0b crossings %0d",
                        $time, rsp_payload.inside_res, rsp_payload.crossings);
               mismatch_count++;
            end else begin
               want = pending_verdicts.pop_front();
               if (rsp_payload.inside_res !== want.inside_res) begin
                  $display("%0t: inside_res mismatch, expected %0b, got %0b",
                           $time, want.inside_res, rsp_payload.inside_res);
                  mismatch_count++;
               end
               if (rsp_payload.crossings !== want.crossings) begin
                  $display("%0t: crossings mismatch, expected %0d, got %0d",
                           $time, want.crossings, rsp_payload.crossings);
                  mismatch_count++;
               end
            end
         end
         if (rx_hold) begin
            rsp_pop <= 1'b0;
         end else if (rx_gap != 0) begin
            rx_gap  <= rx_gap - 1;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= 1'b1;
            if (rsp_pop && !rsp_empty) begin
               rx_gap <= pick_gap(rx_idle_pct);
            end
         end
      end
   end

   task automatic push_request(input logic req_kind, input int unsigned slot,
                               input logic signed [COORD_W-1:0] x,
                               input logic signed [COORD_W-1:0] y);
      pip_req_type item;
      item.req_type     = req_kind;
      item.vertex_index = IDX_W'(slot);
      item.coord_x      = x;
      item.coord_y      = y;
      request_queue = {request_queue, item};
      issued_count++;
      if (req_kind == REQ_WRITE) begin
         gen_written[item.vertex_index] = 1'b1;
         gen_x[item.vertex_index]       = x;
         gen_y[item.vertex_index]       = y;
      end
   endtask

   task automatic wait_idle();
      while (accepted_count != issued_count || pending_verdicts.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_vertex_count(input int unsigned value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= CNT_OUT_W'(value);
      do @(posedge clock); while (!csr_ready);
      csr_valid  <= 1'b0;
      poly_count = value & 32'h7F;
      settings_count++;
   endtask

   task automatic run_random_phase(input int unsigned setting);
      int unsigned               n_eff, n_items, scale, k, s, r;
      logic signed [COORD_W-1:0] qx, qy;
      n_eff = (setting > MAX_VERTS) ? MAX_VERTS : setting;
      scale = $urandom_range(SCALE_UNIT, SCALE_FULL);
      tx_idle_pct = idle_choice();
      rx_idle_pct = idle_choice();
      write_vertex_count(setting);
      for (s = 0; s < n_eff; s++) begin
         if (!gen_written[s]) begin
            push_request(REQ_WRITE, s, rand_coord(scale), rand_coord(scale));
         end
      end
      n_items = $urandom_range(40, 120);
      for (k = 0; k < n_items; k++) begin
         if ($urandom_range(0, 99) < 25) begin
            if (n_eff != 0 && $urandom_range(0, 4) != 0) begin
               s = $urandom_range(0, n_eff - 1);
            end else begin
               s = $urandom_range(0, MAX_VERTS - 1);
            end
            push_request(REQ_WRITE, s, rand_coord(scale), rand_coord(scale));
         end else begin
            r = $urandom_range(0, 99);
            s = (n_eff != 0) ? $urandom_range(0, n_eff - 1) : $urandom_range(0, MAX_VERTS - 1);
            if (r < 45 && gen_written[s]) begin
               qy = gen_y[s] + (int'($urandom_range(0, 2)) - 1);
               if ($urandom_range(0, 1) != 0) begin
                  qx = gen_x[s] + (int'($urandom_range(0, 8)) - 4);
               end else begin
                  qx = rand_coord(scale);
               end
            end else if (r < 70) begin
               qx = rand_coord(scale);
               qy = rand_coord(scale);
            end else if (r < 85) begin
               qx = rand_coord(SCALE_FULL);
               qy = rand_coord(SCALE_FULL);
            end else begin
               qx = rand_coord(SCALE_EDGE);
               qy = rand_coord(SCALE_EDGE);
            end
            push_request(REQ_QUERY, $urandom_range(0, MAX_VERTS - 1), qx, qy);
         end
      end
      wait_idle();
   endtask

   initial begin
      int unsigned first_settings[8];
      int unsigned p, setting;
      first_settings = '{64, 127, 3, 0, 65, 1, 2, 100};
      for (p = 0; p < MAX_VERTS; p++) begin
         gen_written[p] = 1'b0;
      end
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // empty polygon, then a single vertex
      push_request(REQ_QUERY, 0, '0, '0);
      push_request(REQ_QUERY, MAX_VERTS - 1, C_MIN, C_MAX);
      push_request(REQ_WRITE, 0, C_MAX, C_MIN);
      push_request(REQ_QUERY, 0, C_MAX, C_MIN);
      wait_idle();
      write_vertex_count(1);
      push_request(REQ_QUERY, 0, '0, '0);
      push_request(REQ_QUERY, 0, C_MIN, C_MAX);
      push_request(REQ_WRITE, 0, -SQ, -SQ);
      push_request(REQ_WRITE, 1,  SQ, -SQ);
      push_request(REQ_WRITE, 2,  SQ,  SQ);
      push_request(REQ_WRITE, 3, -SQ,  SQ);
      wait_idle();

      // small square: inside, left, right, on a top edge, on a corner
      write_vertex_count(4);
      push_request(REQ_QUERY, 0, '0, '0);
      push_request(REQ_QUERY, 0, -2 * SQ, '0);
      push_request(REQ_QUERY, 0, 2 * SQ, '0);
      push_request(REQ_QUERY, 0, '0, SQ);
      push_request(REQ_QUERY, 0, -SQ, -SQ);
      push_request(REQ_WRITE, 0, C_MIN, C_MIN);
      push_request(REQ_WRITE, 1, C_MAX, C_MIN);
      push_request(REQ_WRITE, 2, C_MAX, C_MAX);
      push_request(REQ_WRITE, 3, C_MIN, C_MAX);

      // square spanning the full coordinate range
      push_request(REQ_QUERY, 0, '0, '0);
      push_request(REQ_QUERY, 0, C_MIN, '0);
      push_request(REQ_QUERY, 0, C_MAX, C_MAX - 1);
      push_request(REQ_QUERY, 0, C_MIN, C_MIN);
      wait_idle();

      p = 0;
      while (issued_count < ITEM_TARGET) begin
         if (p < 8) begin
            setting = first_settings[p];
         end else begin
            case ($urandom_range(0, 9))
               0, 1, 2, 3, 4: setting = $urandom_range(3, 12);
               5, 6, 7:       setting = $urandom_range(13, MAX_VERTS);
               default:       setting = $urandom_range(0, 127);
            endcase
         end
         run_random_phase(setting);
         p++;
      end

      $display("run covered %0d requests: %0d vertex writes and %0d queries, %0d inside",
               accepted_count, write_count, query_count, inside_hits);
      $display("over %0d vertex-count settings, with %0d cycles of request back-pressure",
               settings_count, full_stalls);
      if (mismatch_count == 0) begin
         $display("point_in_polygon_test_core test passed");
      end else begin
         $display("point_in_polygon_test_core test failed");
      end
      $finish;
   end

   // stall responses long enough to back the core up while requests keep coming
   initial begin
      while (!(accepted_count > 300 && issued_count - accepted_count > 20)) begin
         @(posedge clock);
      end
      rx_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      rx_hold <= 1'b0;
   end

   initial begin
      #20_000_000;
      $display("point_in_polygon_test_core test failed");
      $finish;
   end

endmodule
